// File: hw/rtl/psc_pkg.sv
package psc_pkg;

    localparam int COUNT_W  = 16;
    localparam int SPEED_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int MULT_W   = 8;
    localparam int SCALE_W  = 16;
    localparam int LIMIT_W  = 47;
    localparam int K_W      = GAIN_W + MULT_W;      // gain times multiplier
    localparam int DIFF_W   = SPEED_W + 1;          // error difference
    localparam int MA_W     = DIFF_W;               // multiplier operand A, signed
    localparam int MB_W     = K_W + 1;              // multiplier operand B, signed
    localparam int PROD_W   = MA_W + MB_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int INTEG_W  = 48;
    localparam int DRIVE_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MULT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;

    localparam logic signed [SPEED_W-1:0] RST_SET_SPEED   = '0;
    localparam logic [GAIN_W-1:0]         RST_PROP_GAIN   = 16'd1000;
    localparam logic [GAIN_W-1:0]         RST_INTEG_GAIN  = 16'd400;
    localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN  = 16'd0;
    localparam logic [MULT_W-1:0]         RST_GAIN_MULT   = 8'd10;
    localparam logic [SCALE_W-1:0]        RST_SPEED_SCALE = 16'd32768;
    localparam logic [LIMIT_W-1:0]        RST_INTEG_LIMIT = 47'd1099511627776;

    typedef struct packed {
        logic signed [SPEED_W-1:0] set_speed;
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         integ_gain;
        logic [GAIN_W-1:0]         deriv_gain;
        logic [MULT_W-1:0]         gain_mult;
        logic [SCALE_W-1:0]        speed_scale;
        logic [LIMIT_W-1:0]        integ_limit;
    } t_cfg;

    // one datapath step per cycle; the output step can wait on the output register
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SPEED,   // prod = count * scale
        OP_ERR,     // err = sat(set - speed); prod = kp
        OP_P,       // prod = err * kp; diff = err - prev
        OP_KD,      // sum = P; prod = kd
        OP_D,       // prod = diff * kd
        OP_KI,      // sum += D; prod = ki
        OP_I,       // prod = err * ki; prev = err
        OP_INTEG,   // integrator update with clamp
        OP_OUT      // final sum, saturate, load output
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/psc_regs.sv
module psc_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output psc_pkg::t_cfg                     o_cfg
);
    import psc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_speed   <= RST_SET_SPEED;
            r_cfg.prop_gain   <= RST_PROP_GAIN;
            r_cfg.integ_gain  <= RST_INTEG_GAIN;
            r_cfg.deriv_gain  <= RST_DERIV_GAIN;
            r_cfg.gain_mult   <= RST_GAIN_MULT;
            r_cfg.speed_scale <= RST_SPEED_SCALE;
            r_cfg.integ_limit <= RST_INTEG_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SET_SPEED:   r_cfg.set_speed   <= $signed(i_cfg_data[SPEED_W-1:0]);
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_MULT:   r_cfg.gain_mult   <= i_cfg_data[MULT_W-1:0];
                REG_SPEED_SCALE: r_cfg.speed_scale <= i_cfg_data[SCALE_W-1:0];
                REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/psc_ctrl.sv
module psc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  psc_pkg::t_dp_status   i_status,
    output psc_pkg::t_dp_cmd      o_cmd
);
    import psc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SPEED, ST_ERR, ST_P, ST_KD, ST_D, ST_KI, ST_I, ST_INTEG, ST_OUT
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NONE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_SPEED;
                        r_op    <= OP_SPEED;
                        r_ready <= 1'b0;
                    end
                end
                ST_SPEED: begin
                    r_state <= ST_ERR;
                    r_op    <= OP_ERR;
                end
                ST_ERR: begin
                    r_state <= ST_P;
                    r_op    <= OP_P;
                end
                ST_P: begin
                    r_state <= ST_KD;
                    r_op    <= OP_KD;
                end
                ST_KD: begin
                    r_state <= ST_D;
                    r_op    <= OP_D;
                end
                ST_D: begin
                    r_state <= ST_KI;
                    r_op    <= OP_KI;
                end
                ST_KI: begin
                    r_state <= ST_I;
                    r_op    <= OP_I;
                end
                ST_I: begin
                    r_state <= ST_INTEG;
                    r_op    <= OP_INTEG;
                end
                ST_INTEG: begin
                    r_state <= ST_OUT;
                    r_op    <= OP_OUT;
                end
                ST_OUT: begin
                    // hold until the output register can take the result
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_op    <= OP_NONE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_op    <= OP_NONE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd.load = i_in_valid && r_ready;
    assign o_cmd.op   = r_op;

endmodule

// File: hw/rtl/psc_datapath.sv
module psc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  psc_pkg::t_cfg                        i_cfg,
    input  psc_pkg::t_dp_cmd                     i_cmd,
    output psc_pkg::t_dp_status                  o_status,
    input  logic signed [psc_pkg::COUNT_W-1:0]   i_count,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0]   o_drive,
    output logic                                 o_clamped
);
    import psc_pkg::*;

    localparam logic signed [SUM_W-1:0] DRIVE_MAX =
        SUM_W'({1'b0, {(DRIVE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = -DRIVE_MAX - SUM_W'(1);

    logic signed [COUNT_W-1:0] r_count;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SPEED_W-1:0] r_err;
    logic signed [SPEED_W-1:0] r_prev;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_clamp;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_out_clamp;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [DIFF_W-1:0]  err_raw;
    logic signed [SPEED_W-1:0] err_sat;
    logic signed [SUM_W-1:0]   acc;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [SUM_W-1:0]   total;
    logic signed [DRIVE_W-1:0] drive_sat;
    logic                      out_free;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SPEED: begin
                mul_a = MA_W'(r_count);
                mul_b = $signed({{(MB_W-SCALE_W){1'b0}}, i_cfg.speed_scale});
            end
            OP_ERR: begin
                mul_a = $signed({{(MA_W-GAIN_W){1'b0}}, i_cfg.prop_gain});
                mul_b = $signed({{(MB_W-MULT_W){1'b0}}, i_cfg.gain_mult});
            end
            OP_KD: begin
                mul_a = $signed({{(MA_W-GAIN_W){1'b0}}, i_cfg.deriv_gain});
                mul_b = $signed({{(MB_W-MULT_W){1'b0}}, i_cfg.gain_mult});
            end
            OP_KI: begin
                mul_a = $signed({{(MA_W-GAIN_W){1'b0}}, i_cfg.integ_gain});
                mul_b = $signed({{(MB_W-MULT_W){1'b0}}, i_cfg.gain_mult});
            end
            OP_P, OP_I: begin
                mul_a = MA_W'(r_err);
                mul_b = $signed({1'b0, r_prod[K_W-1:0]});
            end
            OP_D: begin
                mul_a = r_diff;
                mul_b = $signed({1'b0, r_prod[K_W-1:0]});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // error with saturation to 32 bits
    assign err_raw = DIFF_W'(i_cfg.set_speed) - DIFF_W'($signed(r_prod[SPEED_W-1:0]));
    always_comb begin
        if (err_raw[DIFF_W-1] != err_raw[DIFF_W-2]) begin
            err_sat = err_raw[DIFF_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                        : {1'b0, {(SPEED_W-1){1'b1}}};
        end else begin
            err_sat = err_raw[SPEED_W-1:0];
        end
    end

    // integrator update; exact limit is not a clamp
    assign acc     = SUM_W'(r_integ) + SUM_W'(r_prod);
    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, i_cfg.integ_limit});
    assign lim_neg = -lim_pos;

    // output sum and 48-bit saturation
    assign total = r_sum + SUM_W'(r_integ);
    always_comb begin
        if (total > DRIVE_MAX) begin
            drive_sat = DRIVE_MAX[DRIVE_W-1:0];
        end else if (total < DRIVE_MIN) begin
            drive_sat = DRIVE_MIN[DRIVE_W-1:0];
        end else begin
            drive_sat = total[DRIVE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= i_count;
        end
        case (i_cmd.op)
            OP_SPEED, OP_KD, OP_D, OP_KI, OP_I: r_prod <= mul_p;
            OP_ERR: begin
                r_prod <= mul_p;
                r_err  <= err_sat;
            end
            OP_P: begin
                r_prod <= mul_p;
                r_diff <= DIFF_W'(r_err) - DIFF_W'(r_prev);
            end
            default: ;
        endcase
        if (i_cmd.op == OP_KD) begin
            r_sum <= SUM_W'(r_prod);
        end
        if (i_cmd.op == OP_KI) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        if (i_cmd.op == OP_OUT && out_free) begin
            r_drive     <= drive_sat;
            r_out_clamp <= r_clamp;
        end
    end

    // architectural state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_integ     <= '0;
            r_clamp     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_I) begin
                r_prev <= r_err;
            end
            if (i_cmd.op == OP_INTEG) begin
                if (acc > lim_pos) begin
                    r_integ <= lim_pos[INTEG_W-1:0];
                    r_clamp <= 1'b1;
                end else if (acc < lim_neg) begin
                    r_integ <= lim_neg[INTEG_W-1:0];
                    r_clamp <= 1'b1;
                end else begin
                    r_integ <= acc[INTEG_W-1:0];
                    r_clamp <= 1'b0;
                end
            end
            if (i_cmd.op == OP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;
    assign o_clamped         = r_out_clamp;

endmodule

// File: hw/rtl/pid_speed_controller.sv
// Positional PID speed loop, fixed point, one item per control tick.
//
// Input stream (s_axis): one signed 16-bit encoder count per item. The count
// is scaled to a Q16.16 speed, compared with the setpoint, and the P, I and D
// terms are formed with gains times the common multiplier.
// Output stream (m_axis): tdata carries the saturated 48-bit drive value,
// tuser flags that the integrator was clamped on this tick.
// Config port: write enable, register index, data; a write lands on the
// clock edge, no read-back. Write only while no item is in flight.
//
// Sequencing: a sequencer steps one shared 33x25 multiplier through speed,
// gain and term products, one step per cycle unless the last step waits on
// the output register. A new item is taken on the cycle after the result is
// loaded, so only one item is in flight at a time.
// Stall: the output register holds its item until taken; a finished item
// waits in the last step with the input not ready, so nothing is overwritten.
// Reset: registers return to their defaults, previous error and integrator
// to zero, output stream empty, input ready.
module pid_speed_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item: encoder_count [15:0]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,
    // result item: drive_value [47:0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [47:0]                       o_m_axis_tdata,
    // result flag: integ_clamped [0]
    output logic [0:0]                        o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import psc_pkg::*;

    t_cfg                      cfg;
    t_dp_cmd                   cmd;
    t_dp_status                status;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;

    psc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer: one step per cycle, waits on the output register
    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    psc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_count     ($signed(i_s_axis_tdata)),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_drive     (drive),
        .o_clamped   (clamped)
    );

    assign o_m_axis_tdata = drive;
    assign o_m_axis_tuser = clamped;

endmodule
